>>> rtl/buddy_page_allocator_core_macros.svh
// Assertion macros for the buddy page allocator core.
// Included by every RTL file that carries concurrent assertions; needs clk and rst in scope.
`ifndef BUDDY_PAGE_ALLOCATOR_CORE_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define BPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BPA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BPA_ASSERT(lbl, prop, msg)
`define BPA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/bpa_pkg.sv
// Types and fixed widths shared by the buddy page allocator modules.
// No dependencies.
package bpa_pkg;

  localparam int SEG_BASE_W  = 20;
  localparam int SEG_PAGES_W = 13;
  localparam int PAGE_IDX_W  = 12;
  localparam int CNT_W       = 13;
  localparam int RES_PAGE_W  = 12;
  localparam int PPN_W       = 21;
  localparam int ORD_CW      = 5;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SEG_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_PAGES = 1'b1;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } bpa_act_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BAD     = 2'd2
  } bpa_status_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_A_ORD,
    S_A_SCAN,
    S_A_SPLIT,
    S_F_START,
    S_F_TZ,
    S_F_N1,
    S_F_LOG,
    S_B_TAGRD,
    S_B_TAGCHK,
    S_B_BUD,
    S_B_BUDCHK,
    S_F_ADV,
    S_D_RD,
    S_D_WR,
    S_ADD1,
    S_ADD2,
    S_DONE
  } bpa_state_t;

  typedef struct packed {
    bpa_act_t               action;
    logic [PAGE_IDX_W-1:0]  page_index;
    logic [CNT_W-1:0]       page_count;
  } bpa_req_t;

  typedef struct packed {
    bpa_status_t            status;
    logic [RES_PAGE_W-1:0]  granted_page;
  } bpa_res_t;

endpackage

>>> rtl/bpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/bpa_engine.sv
// Sequencer of the buddy allocator: free lists, tag and link memories, order search.
// Depends on bpa_pkg, bpa_ram and the assertion macro header.
`include "buddy_page_allocator_core_macros.svh"
module bpa_engine import bpa_pkg::*; #(
  parameter int PAGE_SLOTS   = 4096,
  parameter int ORDER_LEVELS = 9
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  bpa_req_t               req,
  input  logic [SEG_BASE_W-1:0]  seg_base,
  input  logic [SEG_PAGES_W-1:0] seg_pages,
  input  logic                   out_free,
  output logic                   idle,
  output logic                   res_valid,
  output bpa_res_t               res
);

  localparam int PW  = $clog2(PAGE_SLOTS);
  localparam int IW  = $clog2(PAGE_SLOTS + 1);
  localparam int LW  = IW;
  localparam int TW  = $clog2(ORDER_LEVELS + 1);
  localparam int LIW = $clog2(ORDER_LEVELS);
  localparam logic [LW-1:0]     NONE     = LW'(PAGE_SLOTS);
  localparam logic [TW-1:0]     NOT_FREE = TW'(ORDER_LEVELS);
  localparam logic [PPN_W-1:0]  SLOTS_P  = PPN_W'(PAGE_SLOTS);
  localparam logic [ORD_CW-1:0] LEVELS_O = ORD_CW'(ORDER_LEVELS);
  localparam logic [PW-1:0]     LAST_PG  = PW'(PAGE_SLOTS - 1);

  bpa_state_t st, st_next;

  bpa_act_t          act;
  logic [IW-1:0]     cur_idx;
  logic [CNT_W-1:0]  cnt;
  logic [ORD_CW-1:0] o, req_ord, n_ord, bo;
  logic [LIW-1:0]    lo;
  logic [PW-1:0]     p, h, clr;
  logic [LW-1:0]     t;
  logic [PPN_W-1:0]  ppn;
  logic              rem;
  bpa_status_t       status;
  logic [RES_PAGE_W-1:0] granted;

  logic [LW-1:0] head [ORDER_LEVELS];
  logic [LW-1:0] tail [ORDER_LEVELS];

  // memory ports
  logic          tag_we, nxt_we, prv_we;
  logic [PW-1:0] tag_wa, tag_ra, nxt_wa, prv_wa;
  logic [TW-1:0] tag_wd, tag_q;
  logic [LW-1:0] nxt_wd, prv_wd, nxt_q, prv_q;

  // shared arithmetic
  logic [PPN_W-1:0] size_p, base_p, pow_o, pow_req, pow_n, pow_bo;
  logic [PPN_W-1:0] ppn_idx, bppn, bidx_p, split_p, rel_p, req_end;
  logic             req_bad, add_link, d_ok, pr_none, nx_none, tz_go;
  logic [LW-1:0]    pr_n, nx_n, head_o;
  logic [LIW-1:0]   d_i, o_i;

  assign size_p  = (PPN_W'(seg_pages) > SLOTS_P) ? SLOTS_P : PPN_W'(seg_pages);
  assign base_p  = PPN_W'(seg_base);
  assign pow_o   = PPN_W'(1) << o;
  assign pow_req = PPN_W'(1) << req_ord;
  assign pow_n   = PPN_W'(1) << n_ord;
  assign pow_bo  = PPN_W'(1) << bo;
  assign ppn_idx = base_p + PPN_W'(cur_idx);
  assign bppn    = ppn ^ pow_bo;
  assign bidx_p  = bppn - base_p;
  assign rel_p   = ppn - base_p;
  assign split_p = PPN_W'(h) + (PPN_W'(1) << (o - ORD_CW'(1)));
  assign req_end = PPN_W'(req.page_index) + PPN_W'(req.page_count);
  assign req_bad = (req.page_count == '0) ||
                   ((req.action == ACT_FREE) && (req_end > size_p));
  assign o_i     = o[LIW-1:0];
  assign head_o  = head[o_i];
  assign add_link = !((head[lo] >= NONE) || (tail[lo] >= NONE));
  assign tz_go   = (ORD_CW'(o + ORD_CW'(1)) < LEVELS_O) && !ppn[o];

  // unlink: order comes from the tag, links from the link memories
  assign d_ok    = ORD_CW'(tag_q) < LEVELS_O;
  assign d_i     = tag_q[LIW-1:0];
  assign pr_none = prv_q >= NONE;
  assign nx_none = nxt_q >= NONE;
  assign pr_n    = pr_none ? NONE : prv_q;
  assign nx_n    = nx_none ? NONE : nxt_q;

  bpa_ram #(.WIDTH(TW), .DEPTH(PAGE_SLOTS)) u_tag_ram (
    .clk(clk), .we(tag_we), .waddr(tag_wa), .wdata(tag_wd), .raddr(tag_ra), .rdata(tag_q)
  );
  bpa_ram #(.WIDTH(LW), .DEPTH(PAGE_SLOTS)) u_next_ram (
    .clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd), .raddr(p), .rdata(nxt_q)
  );
  bpa_ram #(.WIDTH(LW), .DEPTH(PAGE_SLOTS)) u_prev_ram (
    .clk(clk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd), .raddr(p), .rdata(prv_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_CLEAR;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next = st;
    tag_we = 1'b0; tag_wa = p; tag_wd = NOT_FREE; tag_ra = p;
    nxt_we = 1'b0; nxt_wa = p; nxt_wd = NONE;
    prv_we = 1'b0; prv_wa = p; prv_wd = t;
    case (st)
      S_CLEAR: begin
        tag_we = 1'b1;
        tag_wa = clr;
        if (clr == LAST_PG) st_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (req_bad) st_next = S_DONE;
          else if (req.action == ACT_FREE) st_next = S_F_START;
          else st_next = S_A_ORD;
        end
      end
      S_A_ORD: begin
        if (pow_req >= PPN_W'(cnt)) st_next = S_A_SCAN;
      end
      S_A_SCAN: begin
        if (o >= LEVELS_O) st_next = S_DONE;
        else if (head_o < NONE) st_next = S_D_RD;
      end
      S_D_RD: st_next = S_D_WR;
      S_D_WR: begin
        tag_we = 1'b1;
        if (d_ok) begin
          nxt_we = !pr_none;
          nxt_wa = PW'(prv_q);
          nxt_wd = nx_n;
          prv_we = !nx_none;
          prv_wa = PW'(nxt_q);
          prv_wd = pr_n;
        end
        st_next = (act == ACT_ALLOC) ? S_A_SPLIT : S_B_BUD;
      end
      S_A_SPLIT: begin
        if (o > req_ord) begin
          if (split_p < SLOTS_P) st_next = S_ADD1;
        end else begin
          st_next = S_DONE;
        end
      end
      S_ADD1: begin
        tag_we = 1'b1;
        tag_wd = TW'(lo);
        nxt_we = 1'b1;
        prv_we = 1'b1;
        prv_wd = tail[lo];
        if (add_link) st_next = S_ADD2;
        else st_next = (act == ACT_ALLOC) ? S_A_SPLIT : S_F_ADV;
      end
      S_ADD2: begin
        nxt_we = 1'b1;
        nxt_wa = PW'(t);
        nxt_wd = LW'(p);
        st_next = (act == ACT_ALLOC) ? S_A_SPLIT : S_F_ADV;
      end
      S_F_START: st_next = S_F_TZ;
      S_F_TZ: begin
        if (!tz_go) st_next = S_F_N1;
      end
      S_F_N1: begin
        if (pow_o > PPN_W'(cnt)) st_next = (cnt == '0) ? S_DONE : S_F_LOG;
        else st_next = S_B_TAGRD;
      end
      S_F_LOG: begin
        if ((cnt >> (o + ORD_CW'(1))) == '0) st_next = S_B_TAGRD;
      end
      S_B_TAGRD: begin
        tag_ra = PW'(cur_idx);
        st_next = S_B_TAGCHK;
      end
      S_B_TAGCHK: st_next = (tag_q != NOT_FREE) ? S_F_ADV : S_B_BUD;
      S_B_BUD: begin
        tag_ra = PW'(bidx_p);
        if ((ORD_CW'(bo + ORD_CW'(1)) >= LEVELS_O) || (bppn < base_p) || (bidx_p >= size_p))
          st_next = S_ADD1;
        else
          st_next = S_B_BUDCHK;
      end
      S_B_BUDCHK: st_next = (ORD_CW'(tag_q) == bo) ? S_D_RD : S_ADD1;
      S_F_ADV: begin
        if (!rem) st_next = S_F_START;
        else if (cnt == CNT_W'(pow_n)) st_next = S_DONE;
        else st_next = S_F_LOG;
      end
      S_DONE: begin
        if (out_free) st_next = S_IDLE;
      end
      default: st_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (st == S_CLEAR) begin
      clr <= clr + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (st)
      S_IDLE: begin
        if (start) begin
          act     <= req.action;
          cnt     <= req.page_count;
          cur_idx <= IW'(req.page_index);
          req_ord <= '0;
          o       <= '0;
          rem     <= 1'b0;
          status  <= req_bad ? ST_BAD : ST_OK;
          granted <= '0;
        end
      end
      S_A_ORD: begin
        if (pow_req < PPN_W'(cnt)) req_ord <= req_ord + ORD_CW'(1);
        else o <= req_ord;
      end
      S_A_SCAN: begin
        if (o >= LEVELS_O) status <= ST_NOSPACE;
        else if (head_o >= NONE) o <= o + ORD_CW'(1);
        else begin
          h <= PW'(head_o);
          p <= PW'(head_o);
        end
      end
      S_D_WR: begin
        if (act == ACT_FREE) begin
          bo  <= bo + ORD_CW'(1);
          ppn <= ppn & ~((PPN_W'(1) << (bo + ORD_CW'(1))) - PPN_W'(1));
        end
      end
      S_A_SPLIT: begin
        if (o > req_ord) begin
          o  <= o - ORD_CW'(1);
          p  <= PW'(split_p);
          lo <= LIW'(o - ORD_CW'(1));
        end else begin
          granted <= RES_PAGE_W'(h);
        end
      end
      S_ADD1: t <= tail[lo];
      S_F_START: begin
        ppn <= ppn_idx;
        o   <= '0;
      end
      S_F_TZ: begin
        if (tz_go) o <= o + ORD_CW'(1);
      end
      S_F_N1: begin
        if (pow_o > PPN_W'(cnt)) begin
          rem <= 1'b1;
          o   <= '0;
        end else begin
          n_ord <= o;
          bo    <= o;
        end
      end
      S_F_LOG: begin
        if ((cnt >> (o + ORD_CW'(1))) != '0) o <= o + ORD_CW'(1);
        else begin
          n_ord <= o;
          bo    <= o;
        end
      end
      S_B_TAGCHK: ppn <= ppn_idx;
      S_B_BUD: begin
        lo <= LIW'(bo);
        if ((ORD_CW'(bo + ORD_CW'(1)) >= LEVELS_O) || (bppn < base_p) || (bidx_p >= size_p))
          p <= PW'(rel_p);
        else
          p <= PW'(bidx_p);
      end
      S_B_BUDCHK: begin
        if (ORD_CW'(tag_q) != bo) p <= PW'(rel_p);
      end
      S_F_ADV: begin
        cnt     <= cnt - CNT_W'(pow_n);
        cur_idx <= cur_idx + IW'(pow_n);
        o       <= '0;
      end
      default: ;
    endcase
  end

  // list heads and tails
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ORDER_LEVELS; i++) begin
        head[i] <= NONE;
        tail[i] <= NONE;
      end
    end else begin
      case (st)
        S_D_WR: begin
          if (d_ok) begin
            if (pr_none) head[d_i] <= nx_n;
            if (nx_none) tail[d_i] <= pr_n;
          end
        end
        S_ADD1: begin
          if (!add_link) head[lo] <= LW'(p);
          tail[lo] <= LW'(p);
        end
        default: ;
      endcase
    end
  end

  assign idle      = (st == S_IDLE);
  assign res_valid = (st == S_DONE) && out_free;
  assign res.status       = status;
  assign res.granted_page = granted;

  `BPA_ASSERT(a_busy_after_start, start |=> !idle, "engine still idle after taking a request")
  `BPA_ASSERT(a_unlink_after_read, (st == S_D_WR) |-> ($past(st) == S_D_RD),
              "unlink write without a link read one cycle before")
  `BPA_ASSERT(a_tail_link_valid, (st == S_ADD2) |-> (t < NONE),
              "tail link write through an empty tail")
  `BPA_ASSERT_ALWAYS(a_grant_zero, (res_valid && (res.status != ST_OK)) |-> (res.granted_page == '0),
                     "nonzero page on a failed or bad request")

endmodule

>>> rtl/buddy_page_allocator_core.sv
// Buddy page allocator top level: request/result streams, configuration registers, result register.
// Depends on bpa_pkg and bpa_engine.
//
// Usage:
//   Requests enter on the s_ channel: s_tuser is the action (0 allocate, 1 free), s_tdata
//   carries page_index and page_count. Every request gives exactly one result on the m_
//   channel: m_tuser is the status (0 done, 1 no block large enough, 2 bad request),
//   m_tdata the granted page (zero for frees and failures).
//   Configuration (segment base page, segment page count) is written through cfg_we /
//   cfg_index / cfg_wdata; the user is to write it only while no request is in flight,
//   which the block itself does not enforce. One request is worked at a time and s_tready is
//   high only while the sequencer is idle. An alloc searches the order of the request,
//   scans the free lists from that order upward, unlinks the head of the first one that
//   is not empty and splits it down to the requested order. A free works through the range
//   block by block: it probes alignment and size orders, then merges with each free buddy;
//   a block that is already free is skipped after its probes. A bad request touches no memory.
//   After reset the tag memory is swept, one page a cycle; no request is taken during the
//   sweep, configuration writes are.
//   A finished result sits in the output register until taken; a stalled receiver holds
//   the sequencer in its done step, and the next request is taken once it has left.
module buddy_page_allocator_core import bpa_pkg::*; #(
  parameter int PAGE_SLOTS   = 4096,
  parameter int ORDER_LEVELS = 9
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [31:0]            s_tdata,   // page_index[11:0], page_count[24:12]
  input  logic                   s_tuser,   // action[0]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [15:0]            m_tdata,   // granted_page[11:0]
  output logic [1:0]             m_tuser,   // status[1:0]
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [SEG_BASE_W-1:0]  cfg_wdata
);

  logic [SEG_BASE_W-1:0]  seg_base;
  logic [SEG_PAGES_W-1:0] seg_pages;
  logic                   idle, start, out_free, res_valid;
  bpa_req_t               req;
  bpa_res_t               res, out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_base  <= '0;
      seg_pages <= SEG_PAGES_W'(4096);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEG_BASE:  seg_base  <= cfg_wdata;
        REG_SEG_PAGES: seg_pages <= cfg_wdata[SEG_PAGES_W-1:0];
        default: ;
      endcase
    end
  end

  assign req.action     = bpa_act_t'(s_tuser);
  assign req.page_index = s_tdata[PAGE_IDX_W-1:0];
  assign req.page_count = s_tdata[PAGE_IDX_W +: CNT_W];
  assign s_tready = idle;
  assign start    = s_tvalid && idle;
  assign out_free = !m_tvalid || m_tready;

  bpa_engine #(.PAGE_SLOTS(PAGE_SLOTS), .ORDER_LEVELS(ORDER_LEVELS)) u_engine (
    .clk(clk), .rst(rst), .start(start), .req(req), .seg_base(seg_base),
    .seg_pages(seg_pages), .out_free(out_free), .idle(idle),
    .res_valid(res_valid), .res(res)
  );

  // result register: load when free, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) out_q <= res;
  end

  assign m_tdata = {{(16 - RES_PAGE_W){1'b0}}, out_q.granted_page};
  assign m_tuser = out_q.status;

endmodule
